>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

>>> rtl/core/ras_pkg.sv
package ras_pkg;

  localparam int START_W = 32;
  localparam int TIME_W  = 48;
  localparam int CNT_W   = 32;
  localparam int ROOM_W  = 6;
  localparam int RC_W    = 7;

  typedef logic [START_W-1:0] start_t;
  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ROOM_W-1:0]  room_t;
  typedef logic [RC_W-1:0]    rc_t;

  localparam rc_t RC_RESET = rc_t'(16);

endpackage

>>> rtl/core/ras_if.sv
interface ras_in_if;
  logic              valid;
  logic              ready;
  ras_pkg::start_t   req_start;
  ras_pkg::start_t   req_end;
  logic              last;

  modport source (output valid, output req_start, output req_end, output last, input ready);
  modport sink   (input valid, input req_start, input req_end, input last, output ready);
endinterface

interface ras_out_if;
  logic              valid;
  logic              ready;
  ras_pkg::room_t    assigned_room;
  ras_pkg::time_t    finish_time;
  ras_pkg::room_t    most_used_room;
  logic              most_used_valid;

  modport source (output valid, output assigned_room, output finish_time,
                  output most_used_room, output most_used_valid, input ready);
  modport sink   (input valid, input assigned_room, input finish_time,
                  input most_used_room, input most_used_valid, output ready);
endinterface

interface ras_cfg_if;
  logic              valid;
  logic              ready;
  ras_pkg::rc_t      room_count;

  modport source (output valid, output room_count, input ready);
  modport sink   (input valid, input room_count, output ready);
endinterface

>>> rtl/core/ras_ram.sv
module ras_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/room_allocation_scheduler_core.sv
// room allocation scheduler
// in_if carries one request (req_start, req_end, last); requests of a batch
// must arrive in nondecreasing start order. out_if returns one item per
// request: assigned_room, finish_time and, on the last request of a batch,
// most_used_room with most_used_valid set. cfg_if writes room_count (the
// number of enabled rooms, clamped to 1..MAX_ROOMS); write it only while idle.
// Per request the sequencer walks the room table once through one read port
// of the table ram, drains, updates the chosen room and loads the output
// register. A last request takes a second walk over the use counts. A new
// request is taken only once the result of the previous one is loaded.
// At reset all rooms read as free with zero use, room_count is 16 and no
// result is pending. A stalled receiver holds the result in the output
// register; the block finishes the next request up to that point and waits.
`include "assert_macros.svh"

module room_allocation_scheduler_core #(
  parameter int MAX_ROOMS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ras_in_if.sink    in_if,
  ras_out_if.source out_if,
  ras_cfg_if.sink   cfg_if
);

  localparam int IDX_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
  localparam int ENT_W = ras_pkg::TIME_W + ras_pkg::CNT_W;

  typedef logic [IDX_W-1:0] idx_t;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  localparam ras_pkg::cnt_t CNT_MAX = '1;

  logic [2:0]            state_r, state_nxt;
  logic                  phase_r;
  idx_t                  idx_r;
  logic                  rd_v_r;
  idx_t                  rd_idx_r;
  logic                  ent_v_r;
  logic [MAX_ROOMS-1:0]  valid_r;
  ras_pkg::rc_t          room_count_r;
  logic                  out_valid_r;

  ras_pkg::start_t       start_r;
  ras_pkg::start_t       end_r;
  logic                  last_r;
  logic                  found_r;
  idx_t                  free_idx_r;
  ras_pkg::cnt_t         free_cnt_r;
  idx_t                  min_idx_r;
  ras_pkg::time_t        min_busy_r;
  ras_pkg::cnt_t         min_cnt_r;
  idx_t                  best_idx_r;
  ras_pkg::cnt_t         best_cnt_r;
  idx_t                  res_room_r;
  ras_pkg::time_t        res_finish_r;

  ras_pkg::room_t        out_room_r;
  ras_pkg::time_t        out_finish_r;
  ras_pkg::room_t        out_mu_room_r;
  logic                  out_mu_valid_r;

  ras_pkg::rc_t          n_eff;
  idx_t                  last_idx;
  logic [ENT_W-1:0]      rdata;
  ras_pkg::time_t        eff_busy;
  ras_pkg::cnt_t         eff_cnt;
  idx_t                  sel_idx;
  ras_pkg::cnt_t         sel_cnt;
  ras_pkg::cnt_t         new_cnt;
  ras_pkg::start_t       dur;
  logic [ras_pkg::TIME_W:0] sum;
  ras_pkg::time_t        finish;
  logic                  in_acc;
  logic                  out_load;
  logic                  upd_we;

  always_comb begin
    if (room_count_r == '0) begin
      n_eff = ras_pkg::rc_t'(1);
    end else if (room_count_r > ras_pkg::rc_t'(MAX_ROOMS)) begin
      n_eff = ras_pkg::rc_t'(MAX_ROOMS);
    end else begin
      n_eff = room_count_r;
    end
  end

  assign last_idx = idx_t'(n_eff - ras_pkg::rc_t'(1));

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_acc       = in_if.valid && in_if.ready;
  assign out_load     = (state_r == S_RESULT) && (!out_valid_r || out_if.ready);
  assign upd_we       = (state_r == S_UPDATE);

  assign eff_busy = ent_v_r ? rdata[ras_pkg::CNT_W +: ras_pkg::TIME_W] : '0;
  assign eff_cnt  = ent_v_r ? rdata[ras_pkg::CNT_W-1:0] : '0;

  // update unit
  assign sel_idx = found_r ? free_idx_r : min_idx_r;
  assign sel_cnt = found_r ? free_cnt_r : min_cnt_r;
  assign new_cnt = (sel_cnt == CNT_MAX) ? sel_cnt : sel_cnt + ras_pkg::cnt_t'(1);
  assign dur     = (end_r > start_r) ? end_r - start_r : '0;
  assign sum     = {1'b0, min_busy_r} + (ras_pkg::TIME_W + 1)'(dur);

  always_comb begin
    if (found_r) begin
      finish = ras_pkg::time_t'(end_r);
    end else if (sum[ras_pkg::TIME_W]) begin
      finish = '1;
    end else begin
      finish = sum[ras_pkg::TIME_W-1:0];
    end
  end

  ras_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_ROOMS)
  ) u_table (
    .clk   (clk),
    .we    (upd_we),
    .waddr (sel_idx),
    .wdata ({finish, new_cnt}),
    .raddr (idx_r),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_r == last_idx) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = phase_r ? S_RESULT : S_UPDATE;
      end
      S_UPDATE: begin
        state_nxt = last_r ? S_SCAN : S_RESULT;
      end
      S_RESULT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= 1'b0;
      idx_r        <= '0;
      rd_v_r       <= 1'b0;
      valid_r      <= '0;
      room_count_r <= ras_pkg::RC_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= (state_r == S_SCAN);
      if (cfg_if.valid && cfg_if.ready) begin
        room_count_r <= cfg_if.room_count;
      end
      if (in_acc) begin
        phase_r <= 1'b0;
        idx_r   <= '0;
      end else if (state_r == S_SCAN && idx_r != last_idx) begin
        idx_r <= idx_r + idx_t'(1);
      end else if (state_r == S_UPDATE) begin
        phase_r <= 1'b1;
        idx_r   <= '0;
      end
      if (upd_we) begin
        valid_r[sel_idx] <= 1'b1;
      end
      // batch end clears the whole table
      if (state_r == S_DRAIN && phase_r) begin
        valid_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= idx_r;
    ent_v_r  <= valid_r[idx_r];
    if (in_acc) begin
      start_r <= in_if.req_start;
      end_r   <= in_if.req_end;
      last_r  <= in_if.last;
      found_r <= 1'b0;
    end
    if (rd_v_r && !phase_r) begin
      if (!found_r && eff_busy <= ras_pkg::time_t'(start_r)) begin
        found_r    <= 1'b1;
        free_idx_r <= rd_idx_r;
        free_cnt_r <= eff_cnt;
      end
      if (rd_idx_r == '0 || eff_busy < min_busy_r) begin
        min_idx_r  <= rd_idx_r;
        min_busy_r <= eff_busy;
        min_cnt_r  <= eff_cnt;
      end
    end
    if (rd_v_r && phase_r) begin
      if (rd_idx_r == '0 || eff_cnt > best_cnt_r) begin
        best_idx_r <= rd_idx_r;
        best_cnt_r <= eff_cnt;
      end
    end
    if (upd_we) begin
      res_room_r   <= sel_idx;
      res_finish_r <= finish;
    end
    if (out_load) begin
      out_room_r     <= ras_pkg::room_t'(res_room_r);
      out_finish_r   <= res_finish_r;
      out_mu_room_r  <= last_r ? ras_pkg::room_t'(best_idx_r) : '0;
      out_mu_valid_r <= last_r;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.assigned_room   = out_room_r;
  assign out_if.finish_time     = out_finish_r;
  assign out_if.most_used_room  = out_mu_room_r;
  assign out_if.most_used_valid = out_mu_valid_r;

  `ASSERT_PROP(a_accept_starts_scan, clk, rst_n, in_acc |=> (state_r == S_SCAN && !phase_r && idx_r == '0), "accepted item did not start a scan")
  `ASSERT_PROP(a_pick_in_range, clk, rst_n, upd_we |-> (sel_idx <= last_idx), "picked room outside enabled range")
  `ASSERT_PROP(a_clear_at_batch_end, clk, rst_n, (state_r == S_DRAIN && phase_r) |=> (valid_r == '0), "table not cleared after last item")
  `ASSERT_PROP(a_most_used_in_range, clk, rst_n, (out_if.valid && out_if.most_used_valid) |-> (out_if.most_used_room <= ras_pkg::room_t'(last_idx)), "most used room outside enabled range")
  `ASSERT_NEVER(a_read_outside_scan, clk, rst_n, rd_v_r && !(state_r == S_SCAN || state_r == S_DRAIN), "table read data arrived outside a scan")

endmodule

>>> tb/sv/room_allocation_scheduler_core_test.sv
module room_allocation_scheduler_core_test;

  localparam int MAX_ROOMS = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 1550;
  localparam int PHASES = 10;

  typedef struct packed {
    ras_pkg::room_t assigned_room;
    ras_pkg::time_t finish_time;
    ras_pkg::room_t most_used_room;
    logic           most_used_valid;
  } alloc_t;

  class room_ledger;
    ras_pkg::time_t busy_until [MAX_ROOMS];
    ras_pkg::cnt_t  use_count [MAX_ROOMS];
    ras_pkg::rc_t   room_count;
    alloc_t         due_allocs [$];
    int             errors;

    function new();
      room_count = ras_pkg::RC_RESET;
      errors = 0;
      clear_rooms();
    endfunction

    function void clear_rooms();
      foreach (busy_until[i]) begin
        busy_until[i] = '0;
        use_count[i] = '0;
      end
    endfunction

    function void set_room_count(ras_pkg::rc_t v);
      room_count = v;
    endfunction

    function int pending();
      return due_allocs.size();
    endfunction

    function void book_request(ras_pkg::start_t s, ras_pkg::start_t e, logic is_last);
      int n;
      int pick;
      int best;
      bit found;
      logic [ras_pkg::TIME_W:0] sum;
      ras_pkg::start_t dur;
      alloc_t a;
      n = int'(room_count);
      if (n == 0) n = 1;
      if (n > MAX_ROOMS) n = MAX_ROOMS;
      dur = (e > s) ? ras_pkg::start_t'(e - s) : '0;
      found = 0;
      pick = 0;
      for (int i = 0; i < n; i++) begin
        if (!found && busy_until[i] <= ras_pkg::time_t'(s)) begin
          pick = i;
          found = 1;
        end
      end
      if (found) begin
        a.finish_time = ras_pkg::time_t'(e);
      end else begin
        pick = 0;
        for (int i = 1; i < n; i++) begin
          if (busy_until[i] < busy_until[pick]) pick = i;
        end
        sum = {1'b0, busy_until[pick]} + (ras_pkg::TIME_W + 1)'(dur);
        a.finish_time = sum[ras_pkg::TIME_W] ? '1 : sum[ras_pkg::TIME_W-1:0];
      end
      busy_until[pick] = a.finish_time;
      if (use_count[pick] != '1) use_count[pick] = use_count[pick] + ras_pkg::cnt_t'(1);
      a.assigned_room = ras_pkg::room_t'(pick);
      a.most_used_room = '0;
      a.most_used_valid = 1'b0;
      if (is_last) begin
        best = 0;
        for (int i = 1; i < n; i++) begin
          if (use_count[i] > use_count[best]) best = i;
        end
        a.most_used_room = ras_pkg::room_t'(best);
        a.most_used_valid = 1'b1;
        clear_rooms();
      end
      due_allocs.push_back(a);
    endfunction

    function void flag(string field, ras_pkg::time_t want_v, ras_pkg::time_t got_v);
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want_v, got_v);
    endfunction

    function void match_allocation(alloc_t got);
      alloc_t want;
      if (due_allocs.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none actual room %0h finish %0h",
                 $time, got.assigned_room, got.finish_time);
        return;
      end
      want = due_allocs.pop_front();
      if (got.assigned_room !== want.assigned_room)
        flag("assigned_room", ras_pkg::time_t'(want.assigned_room),
             ras_pkg::time_t'(got.assigned_room));
      if (got.finish_time !== want.finish_time)
        flag("finish_time", want.finish_time, got.finish_time);
      if (got.most_used_room !== want.most_used_room)
        flag("most_used_room", ras_pkg::time_t'(want.most_used_room),
             ras_pkg::time_t'(got.most_used_room));
      if (got.most_used_valid !== want.most_used_valid)
        flag("most_used_valid", ras_pkg::time_t'(want.most_used_valid),
             ras_pkg::time_t'(got.most_used_valid));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int cycles = 0;
  room_ledger board;
  alloc_t seen;

  int rx_left = 0;
  bit rx_free = 0;
  bit tx_free = 0;
  int burst_left = 0;
  int batch_left = 0;
  ras_pkg::start_t cur_start;
  int unsigned step;
  int unsigned span;

  ras_in_if  in_ch ();
  ras_out_if out_ch ();
  ras_cfg_if cfg_ch ();

  room_allocation_scheduler_core #(.MAX_ROOMS(MAX_ROOMS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        seen.assigned_room = out_ch.assigned_room;
        seen.finish_time = out_ch.finish_time;
        seen.most_used_room = out_ch.most_used_room;
        seen.most_used_valid = out_ch.most_used_valid;
        board.match_allocation(seen);
      end
      if (in_ch.valid && in_ch.ready)
        board.book_request(in_ch.req_start, in_ch.req_end, in_ch.last);
      if (cfg_ch.valid && cfg_ch.ready)
        board.set_room_count(cfg_ch.room_count);
    end
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (rx_left > 0) begin
      rx_left--;
    end else if (rx_free || out_ch.ready !== 1'b1) begin
      out_ch.ready = 1'b1;
      rx_left = $urandom_range(0, 15);
    end else begin
      out_ch.ready = 1'b0;
      rx_left = $urandom_range(0, 7);
    end
  end

  function automatic ras_pkg::start_t sat_add(ras_pkg::start_t a, int unsigned b);
    logic [ras_pkg::START_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[ras_pkg::START_W] ? '1 : t[ras_pkg::START_W-1:0];
  endfunction

  task automatic send_item(ras_pkg::start_t s, ras_pkg::start_t e, logic l);
    in_ch.req_start = s;
    in_ch.req_end = e;
    in_ch.last = l;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic settle();
    while (board.pending() != 0) @(negedge clk);
    repeat (2 * MAX_ROOMS + 8) @(negedge clk);
  endtask

  task automatic write_room_count(ras_pkg::rc_t v);
    cfg_ch.room_count = v;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic run_random(int count);
    ras_pkg::start_t s;
    ras_pkg::start_t e;
    logic l;
    int kind;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        if (!tx_free) begin
          in_ch.valid = 1'b0;
          in_ch.req_start = $urandom;
          in_ch.req_end = $urandom;
          repeat ($urandom_range(1, 20)) @(negedge clk);
        end
      end
      burst_left--;
      if (i == count / 2 || $urandom_range(0, 299) == 0) begin
        in_ch.valid = 1'b0;
        while (board.pending() != 0) @(negedge clk);
      end
      if (batch_left == 0) begin
        batch_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        cur_start = ($urandom_range(0, 3) == 0) ? ras_pkg::start_t'($urandom)
                                                : ras_pkg::start_t'($urandom_range(0, 1000));
        step = ($urandom_range(0, 3) == 0) ? 1000 : $urandom_range(0, 20);
        span = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 200);
      end
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        s = $urandom;
      end else begin
        s = sat_add(cur_start, $urandom_range(0, step));
        cur_start = s;
      end
      kind = $urandom_range(0, 19);
      if (kind == 0) e = $urandom;
      else if (kind == 1) e = s;
      else e = sat_add(s, $urandom_range(1, span));
      l = (batch_left == 1) || ($urandom_range(0, 59) == 0);
      if (l) batch_left = 0;
      else batch_left--;
      send_item(s, e, l);
    end
    in_ch.valid = 1'b0;
  endtask

  initial begin
    ras_pkg::rc_t phase_rc [PHASES];
    board = new;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_start = '0;
    in_ch.req_end = '0;
    in_ch.last = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.room_count = ras_pkg::RC_RESET;
    phase_rc = '{7'd16, 7'd1, 7'd0, 7'd64, 7'd127, 7'd2, 7'd17, 7'd4,
                 ras_pkg::rc_t'($urandom_range(0, 127)),
                 ras_pkg::rc_t'($urandom_range(1, 16))};
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // reset room count, extremes of the fields
    send_item('0, '0, 1'b0);
    send_item('0, '1, 1'b0);
    send_item(32'd1, 32'd5, 1'b0);
    send_item(32'd1, 32'd5, 1'b0);
    send_item(32'd2, 32'd3, 1'b0);
    send_item('1, '0, 1'b0);
    send_item('1, '1, 1'b1);
    in_ch.valid = 1'b0;
    settle();

    // single room: delay path, end before start, out of order start
    write_room_count(7'd1);
    send_item(32'd10, 32'd20, 1'b0);
    send_item(32'd10, 32'd30, 1'b0);
    send_item(32'd15, 32'd5, 1'b0);
    send_item(32'd5, 32'd6, 1'b0);
    send_item(32'd100, 32'd200, 1'b1);
    in_ch.valid = 1'b0;
    settle();

    // zero count acts as one room
    write_room_count(7'd0);
    send_item(32'd0, 32'd100, 1'b0);
    send_item(32'd50, 32'd60, 1'b0);
    in_ch.valid = 1'b0;
    settle();

    // count above the table size, batch spans the write
    write_room_count(7'd127);
    send_item(32'd50, 32'd60, 1'b0);
    send_item(32'd50, 32'd70, 1'b0);
    send_item(32'd55, 32'd56, 1'b0);
    send_item(32'd60, 32'd61, 1'b1);
    in_ch.valid = 1'b0;
    settle();

    for (int p = 0; p < PHASES; p++) begin
      write_room_count(phase_rc[p]);
      rx_free = ($urandom_range(0, 3) == 0);
      tx_free = ($urandom_range(0, 3) == 0);
      run_random(RANDOM_ITEMS / PHASES);
      settle();
    end

    if (board.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

>>> room_allocation_scheduler_core.f
+incdir+rtl/core
rtl/core/ras_pkg.sv
rtl/core/ras_if.sv
rtl/core/ras_ram.sv
rtl/core/room_allocation_scheduler_core.sv
tb/sv/room_allocation_scheduler_core_test.sv
